// ===== hw/rtl/rs485_frame_deframer_crc_check_core_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef RS485_FRAME_DEFRAMER_CRC_CHECK_CORE_DEFINES_SVH
`define RS485_FRAME_DEFRAMER_CRC_CHECK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSDF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
`define RSDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define RSDF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RSDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/rsdf_pkg.sv =====
package rsdf_pkg;

   localparam int ID_BYTES_DEF         = 16;
   localparam int FAULT_SCAN_BYTES_DEF = 16;

   localparam int CSR_WIDTH = 16;

   localparam logic [1:0] CSR_HEADER     = 2'd0;
   localparam logic [1:0] CSR_MIN_LEN    = 2'd1;
   localparam logic [1:0] CSR_FAULT_ADDR = 2'd2;
   localparam logic [1:0] CSR_FORCE      = 2'd3;

   localparam logic [7:0]  HEADER_RST     = 8'hAA;
   localparam logic [7:0]  MIN_LEN_RST    = 8'd15;
   localparam logic [15:0] FAULT_ADDR_RST = 16'h0090;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [3:0]  GLITCH_NIBBLE = 4'hF;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_GLITCH   = 3'd1,
      ST_SHORT    = 3'd2,
      ST_NOHEADER = 3'd3,
      ST_TRUNC    = 3'd4,
      ST_CRCERR   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT     = 3'd0,
      PH_ID       = 3'd1,
      PH_FIELDS   = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_CRC_LO   = 3'd4,
      PH_CRC_HI   = 3'd5,
      PH_DONE_OK  = 3'd6,
      PH_DONE_BAD = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [7:0]  min_chunk_len;
      logic [15:0] fault_address;
      logic        force_forward;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  command;
      logic [15:0] reg_address;
      logic [7:0]  data_length;
      logic        payload_nonzero;
      logic        forward;
   } result_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/rsdf_channel_if.sv =====
interface rsdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_chunk;

   modport source (output valid, output rx_byte, output end_of_chunk, input ready);
   modport sink   (input valid, input rx_byte, input end_of_chunk, output ready);
endinterface

interface rsdf_rsp_if;
   import rsdf_pkg::*;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [7:0]  command;
   logic [15:0] reg_address;
   logic [7:0]  data_length;
   logic        payload_nonzero;
   logic        forward;

   modport source (output valid, output status, output command, output reg_address,
                   output data_length, output payload_nonzero, output forward,
                   input ready);
   modport sink   (input valid, input status, input command, input reg_address,
                   input data_length, input payload_nonzero, input forward,
                   output ready);
endinterface

// ===== hw/rtl/rsdf_parser.sv =====
module rsdf_parser #(
   parameter int ID_BYTES         = rsdf_pkg::ID_BYTES_DEF,
   parameter int FAULT_SCAN_BYTES = rsdf_pkg::FAULT_SCAN_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   input  logic                 end_of_chunk,
   input  rsdf_pkg::cfg_type    cfg,
   output logic                 done,
   output rsdf_pkg::result_type result
);
   import rsdf_pkg::*;

   localparam logic [4:0] ID_LIM   = 5'(ID_BYTES);
   localparam logic [4:0] POS_ADDR_HI = 5'd1;
   localparam logic [4:0] POS_ADDR_LO = 5'd2;
   localparam logic [4:0] POS_CMD  = 5'd0;
   localparam logic [8:0] SCAN_LIM = 9'(FAULT_SCAN_BYTES);

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        nz_ff, nz_in;
   logic        glitch_ff, glitch_in;

   logic [4:0]  pos_inc;
   logic [15:0] crc_step;
   logic [7:0]  pay_idx;
   status_type  status;

   assign pos_inc  = pos_ff + 5'd1;
   assign crc_step = crc16_byte((phase_ff == PH_HUNT) ? CRC_INIT : crc_ff, rx_byte);
   assign pay_idx  = len_ff - left_ff;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.header_byte) begin
               phase_in = (ID_BYTES == 0) ? PH_FIELDS : PH_ID;
            end
         end
         PH_ID: begin
            if (pos_inc >= ID_LIM) begin
               phase_in = PH_FIELDS;
            end
         end
         PH_FIELDS: begin
            if (pos_ff > POS_ADDR_LO) begin
               phase_in = (rx_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (left_ff == 8'd1) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: phase_in = PH_CRC_HI;
         PH_CRC_HI: phase_in = ({rx_byte, crc_low_ff} == crc_ff) ? PH_DONE_OK : PH_DONE_BAD;
         PH_DONE_OK: phase_in = phase_ff;
         PH_DONE_BAD: phase_in = phase_ff;
      endcase
   end

   always_comb begin
      pos_in     = pos_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      nz_in      = nz_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.header_byte) begin
               crc_in = crc_step;
               pos_in = 5'd0;
            end
         end
         PH_ID: begin
            crc_in = crc_step;
            pos_in = (pos_inc >= ID_LIM) ? 5'd0 : pos_inc;
         end
         PH_FIELDS: begin
            crc_in = crc_step;
            pos_in = pos_inc;
            priority if (pos_ff == POS_CMD) begin
               cmd_in = rx_byte;
            end else if (pos_ff == POS_ADDR_HI) begin
               addr_in = {rx_byte, 8'h00};
            end else if (pos_ff == POS_ADDR_LO) begin
               addr_in = addr_ff | {8'h00, rx_byte};
            end else begin
               len_in  = rx_byte;
               left_in = rx_byte;
            end
         end
         PH_PAYLOAD: begin
            crc_in  = crc_step;
            left_in = left_ff - 8'd1;
            if (({1'b0, pay_idx} < SCAN_LIM) && (rx_byte != 8'd0)) begin
               nz_in = 1'b1;
            end
         end
         PH_CRC_LO: crc_low_in = rx_byte;
         PH_CRC_HI, PH_DONE_OK, PH_DONE_BAD: begin
         end
      endcase

      glitch_in = (count_ff == 16'd0) ? (rx_byte[7:4] == GLITCH_NIBBLE) : glitch_ff;
      count_in  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;

      priority if ((count_in == 16'd1) && glitch_in) begin
         status = ST_GLITCH;
      end else if (count_in < {8'h00, cfg.min_chunk_len}) begin
         status = ST_SHORT;
      end else if (phase_in == PH_HUNT) begin
         status = ST_NOHEADER;
      end else if (phase_in == PH_DONE_OK) begin
         status = ST_OK;
      end else if (phase_in == PH_DONE_BAD) begin
         status = ST_CRCERR;
      end else begin
         status = ST_TRUNC;
      end

      result = '0;
      result.status = status;
      if (status == ST_OK) begin
         result.command         = cmd_in;
         result.reg_address     = addr_in;
         result.data_length     = len_in;
         result.payload_nonzero = nz_in;
         result.forward = cfg.force_forward || (addr_in != cfg.fault_address) || nz_in;
      end
   end

   assign done = take && end_of_chunk;

   always_ff @(posedge clock) begin
      if (reset || done) begin
         phase_ff   <= PH_HUNT;
         count_ff   <= '0;
         pos_ff     <= '0;
         cmd_ff     <= '0;
         addr_ff    <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= '0;
         nz_ff      <= 1'b0;
         glitch_ff  <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         cmd_ff     <= cmd_in;
         addr_ff    <= addr_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         nz_ff      <= nz_in;
         glitch_ff  <= glitch_in;
      end
   end

endmodule

// ===== hw/rtl/rs485_frame_deframer_crc_check_core.sv =====
// Channel   Dir  Beat
// req_bus   in   one received byte plus end-of-chunk mark
// rsp_bus   out  one frame report (status, fields, forward) per chunk end
// csr_*     in   register write: csr_index selects, csr_wdata carries value
//
// The CRC-16 update of a whole byte is done in the same cycle as the parse step, so
// a byte may follow in every cycle while req_bus is not stalled.
// The report appears in the cycle after the last byte of a chunk is taken and sits
// in a result register until taken; req_bus stalls only while that register is
// full and not being taken. Synchronous reset clears the parser and rsp_bus.valid and reloads the CSR defaults.
`include "rs485_frame_deframer_crc_check_core_defines.svh"

module rs485_frame_deframer_crc_check_core #(
   parameter int ID_BYTES         = rsdf_pkg::ID_BYTES_DEF,
   parameter int FAULT_SCAN_BYTES = rsdf_pkg::FAULT_SCAN_BYTES_DEF
) (
   input logic                           clock,
   input logic                           reset,
   rsdf_req_if.sink                      req_bus,
   rsdf_rsp_if.source                    rsp_bus,
   input logic                           csr_we,
   input logic [1:0]                     csr_index,
   input logic [rsdf_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import rsdf_pkg::*;

   cfg_type    cfg_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff;
   result_type result;
   logic       take;
   logic       done;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign take          = req_bus.valid && req_bus.ready;

   rsdf_parser #(
      .ID_BYTES         (ID_BYTES),
      .FAULT_SCAN_BYTES (FAULT_SCAN_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .rx_byte      (req_bus.rx_byte),
      .end_of_chunk (req_bus.end_of_chunk),
      .cfg          (cfg_ff),
      .done         (done),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte   <= HEADER_RST;
         cfg_ff.min_chunk_len <= MIN_LEN_RST;
         cfg_ff.fault_address <= FAULT_ADDR_RST;
         cfg_ff.force_forward <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER:     cfg_ff.header_byte   <= csr_wdata[7:0];
            CSR_MIN_LEN:    cfg_ff.min_chunk_len <= csr_wdata[7:0];
            CSR_FAULT_ADDR: cfg_ff.fault_address <= csr_wdata[15:0];
            CSR_FORCE:      cfg_ff.force_forward <= csr_wdata[0];
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = result_ff.status;
   assign rsp_bus.command         = result_ff.command;
   assign rsp_bus.reg_address     = result_ff.reg_address;
   assign rsp_bus.data_length     = result_ff.data_length;
   assign rsp_bus.payload_nonzero = result_ff.payload_nonzero;
   assign rsp_bus.forward         = result_ff.forward;

   `RSDF_ASSERT_NEXT(a_chunk_end_reports, clock, reset, take && req_bus.end_of_chunk, rsp_bus.valid)
   `RSDF_ASSERT_IMPL(a_full_stalls_input, clock, reset, rsp_bus.valid && !rsp_bus.ready, !req_bus.ready)
   `RSDF_ASSERT_IMPL(a_forward_rule, clock, reset, rsp_bus.valid && rsp_bus.forward, (rsp_bus.status == ST_OK) && (cfg_ff.force_forward || rsp_bus.payload_nonzero || (rsp_bus.reg_address != cfg_ff.fault_address)))
   `RSDF_ASSERT_IMPL(a_failed_fields_zero, clock, reset, rsp_bus.valid && (rsp_bus.status != ST_OK), (rsp_bus.command == 8'd0) && (rsp_bus.reg_address == 16'd0) && !rsp_bus.forward)

endmodule
